### rtl/audio_record_playback_looper_assert.svh
// ============================================================================
// Assertion macros for the audio record and playback looper
// Shared wrappers around concurrent assertions, clocked on i_clk.
// ============================================================================
`ifndef AUDIO_RECORD_PLAYBACK_LOOPER_ASSERT_SVH
`define AUDIO_RECORD_PLAYBACK_LOOPER_ASSERT_SVH

// Assertion that is switched off while reset is held.
`define ARPL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Assertion that is also checked during reset.
`define ARPL_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### rtl/arpl_pkg.sv
// ============================================================================
// Looper package
// Types, codes and constants shared by the looper modules.
// ============================================================================
package arpl_pkg;

    // Fixed field widths of the request channels.
    localparam int SAMPLE_W      = 16;
    localparam int OP_W          = 3;
    localparam int CHANNEL_W     = 3;
    localparam int MAX_SAMPLES_W = 20;
    localparam int OUT_CH_W      = 4;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 20;

    // Defaults for the top-level parameters.
    localparam int STORE_DEPTH_DEF  = 524288;
    localparam int MAX_CHANNELS_DEF = 8;

    // Register reset values.
    localparam logic [MAX_SAMPLES_W-1:0] MAX_SAMPLES_RST = 20'd480000;
    localparam logic [OUT_CH_W-1:0]      OUT_CH_RST      = 4'd2;

    // Input operation codes.
    typedef enum logic [OP_W-1:0] {
        OP_TICK       = 3'd0,
        OP_REC_START  = 3'd1,
        OP_REC_STOP   = 3'd2,
        OP_PLAY_START = 3'd3,
        OP_PLAY_STOP  = 3'd4
    } t_op;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_SAMPLES  = 2'd0,
        CFG_OUT_CHANNELS = 2'd1
    } t_cfg_idx;

    // Tick descriptor held between the control stage and the channel emitter.
    typedef struct packed {
        logic valid;
        logic rd;
        logic rec;
        logic play;
    } t_s1_info;

endpackage

### rtl/arpl_in_if.sv
// ============================================================================
// Looper input channel
// Valid/ready channel that carries one command or tick request.
// ============================================================================
interface arpl_in_if;
    logic                                valid;
    logic                                ready;
    logic [arpl_pkg::OP_W-1:0]           op;
    logic signed [arpl_pkg::SAMPLE_W-1:0] sample_in;
    logic                                play_reverse;
    logic                                play_loop;
    logic                                play_bounce;

    modport source (
        output valid, op, sample_in, play_reverse, play_loop, play_bounce,
        input  ready
    );
    modport sink (
        input  valid, op, sample_in, play_reverse, play_loop, play_bounce,
        output ready
    );
endinterface

### rtl/arpl_out_if.sv
// ============================================================================
// Looper output channel
// Valid/ready channel that carries one per-channel sample request.
// ============================================================================
interface arpl_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [arpl_pkg::SAMPLE_W-1:0] sample_out;
    logic [arpl_pkg::CHANNEL_W-1:0]       channel;
    logic                                 last;
    logic                                 is_recording;
    logic                                 is_playing;

    modport source (
        output valid, sample_out, channel, last, is_recording, is_playing,
        input  ready
    );
    modport sink (
        input  valid, sample_out, channel, last, is_recording, is_playing,
        output ready
    );
endinterface

### rtl/audio_record_playback_looper.sv
// ============================================================================
// Audio record and playback looper
// Records samples into a store and plays them forward, reversed, looped or
// back and forth, copying each played sample to every output channel.
// ============================================================================
//
//  Port      | Dir | Handshake   | Carries
//  ----------+-----+-------------+--------------------------------------------
//  i_in      | in  | valid/ready | op, sample_in, play_reverse/loop/bounce
//  o_out     | out | valid/ready | sample_out, channel, last, status flags
//  i_cfg_*   | in  | write only  | max_samples (0), out_channels (1)
//
//  Commands leave no result. A tick gives out_channels results (zero counts
//  as one, MAX_CHANNELS at most), one per cycle while o_out is ready, through
//  the tick slot and the emitter registers; the emitter loads the next tick as
//  its last channel leaves, and the store is read at most once a tick.
//  Reset is synchronous and active low; the sample store is not cleared.
//  A stall on o_out holds the emitter, then the tick slot, then i_in.ready.
//
module audio_record_playback_looper #(
    parameter int STORE_DEPTH  = arpl_pkg::STORE_DEPTH_DEF,
    parameter int MAX_CHANNELS = arpl_pkg::MAX_CHANNELS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    arpl_in_if.sink                         i_in,
    arpl_out_if.source                      o_out,
    input  logic                            i_cfg_we,
    input  logic [arpl_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [arpl_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int ADDR_W = $clog2(STORE_DEPTH);
    localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    arpl_pkg::t_s1_info            w_s1;
    logic [CH_W-1:0]               w_s1_last_ch;
    logic                          w_take;
    logic                          w_ram_we;
    logic [ADDR_W-1:0]             w_ram_waddr;
    logic [arpl_pkg::SAMPLE_W-1:0] w_ram_wdata;
    logic                          w_ram_re;
    logic [ADDR_W-1:0]             w_ram_raddr;
    logic [arpl_pkg::SAMPLE_W-1:0] w_ram_q;

    // Control state, configuration and store access.
    arpl_ctrl #(
        .STORE_DEPTH  (STORE_DEPTH),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_take       (w_take),
        .o_s1         (w_s1),
        .o_s1_last_ch (w_s1_last_ch),
        .o_ram_we     (w_ram_we),
        .o_ram_waddr  (w_ram_waddr),
        .o_ram_wdata  (w_ram_wdata),
        .o_ram_re     (w_ram_re),
        .o_ram_raddr  (w_ram_raddr)
    );

    // Sample store.
    arpl_ram #(
        .WIDTH (arpl_pkg::SAMPLE_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_q)
    );

    // Per-channel result sequencing.
    arpl_emit #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s1         (w_s1),
        .i_s1_last_ch (w_s1_last_ch),
        .i_ram_q      (w_ram_q),
        .o_take       (w_take),
        .o_out        (o_out)
    );

endmodule

### rtl/arpl_ram.sv
// ============================================================================
// Generic single-port-write RAM
// One write port and one read port with a registered read.
// ============================================================================
module arpl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; the data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/arpl_ctrl.sv
// ============================================================================
// Looper control stage
// Holds the record/play state and configuration, decodes each request,
// drives the sample store and registers a descriptor for every tick.
// ============================================================================
module arpl_ctrl #(
    parameter int STORE_DEPTH  = arpl_pkg::STORE_DEPTH_DEF,
    parameter int MAX_CHANNELS = arpl_pkg::MAX_CHANNELS_DEF,
    localparam int ADDR_W = $clog2(STORE_DEPTH),
    localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    arpl_in_if.sink                           i_in,
    input  logic                              i_cfg_we,
    input  logic [arpl_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [arpl_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_take,
    output arpl_pkg::t_s1_info                o_s1,
    output logic [CH_W-1:0]                   o_s1_last_ch,
    output logic                              o_ram_we,
    output logic [ADDR_W-1:0]                 o_ram_waddr,
    output logic [arpl_pkg::SAMPLE_W-1:0]     o_ram_wdata,
    output logic                              o_ram_re,
    output logic [ADDR_W-1:0]                 o_ram_raddr
);

    localparam int LEN_W = $clog2(STORE_DEPTH + 1);

    // Configuration registers.
    logic [arpl_pkg::MAX_SAMPLES_W-1:0] r_max_samples;
    logic [arpl_pkg::OUT_CH_W-1:0]      r_out_ch;

    // Record and playback state.
    logic [LEN_W-1:0] r_len, n_len;
    logic [LEN_W-1:0] r_pos, n_pos;
    logic             r_rec, n_rec;
    logic             r_play, n_play;
    logic             r_rev, n_rev;
    logic             r_loop, n_loop;
    logic             r_bounce, n_bounce;

    // Tick descriptor stage.
    logic             r_s1_valid;
    logic             r_s1_rd;
    logic             r_s1_rec;
    logic             r_s1_play;
    logic [CH_W-1:0]  r_s1_last_ch;

    logic             w_fire;
    logic             w_tick;
    logic [31:0]      w_lim32;
    logic [LEN_W-1:0] w_limit;
    logic [LEN_W-1:0] w_pos_base;
    logic             w_rev_eff;
    logic [LEN_W-1:0] w_rd_idx;
    logic [CH_W-1:0]  w_last_ch;

    // The stage accepts a request when its tick slot is free or being drained.
    assign i_in.ready = !r_s1_valid || i_take;
    assign w_fire     = i_in.valid && i_in.ready;

    // Recording limit saturated to the store depth.
    always_comb begin
        w_lim32 = (32'(r_max_samples) > 32'(STORE_DEPTH)) ? 32'(STORE_DEPTH)
                                                          : 32'(r_max_samples);
        w_limit = LEN_W'(w_lim32);
    end

    // Index of the last channel: zero counts as one, large values saturate.
    always_comb begin
        if (r_out_ch == '0) begin
            w_last_ch = '0;
        end else if (32'(r_out_ch) > 32'(MAX_CHANNELS)) begin
            w_last_ch = CH_W'(MAX_CHANNELS - 1);
        end else begin
            w_last_ch = CH_W'(r_out_ch - 1'b1);
        end
    end

    // Next state, store access and tick decode.
    always_comb begin
        n_len       = r_len;
        n_pos       = r_pos;
        n_rec       = r_rec;
        n_play      = r_play;
        n_rev       = r_rev;
        n_loop      = r_loop;
        n_bounce    = r_bounce;
        w_tick      = 1'b0;
        o_ram_we    = 1'b0;
        o_ram_waddr = ADDR_W'(r_len);
        o_ram_wdata = i_in.sample_in;
        o_ram_re    = 1'b0;
        w_pos_base  = (r_pos >= r_len) ? '0 : r_pos;
        w_rev_eff   = (r_pos >= r_len && r_bounce) ? !r_rev : r_rev;
        w_rd_idx    = w_rev_eff ? (r_len - 1'b1 - w_pos_base) : w_pos_base;
        o_ram_raddr = ADDR_W'(w_rd_idx);
        if (w_fire) begin
            unique case (arpl_pkg::t_op'(i_in.op))
                arpl_pkg::OP_REC_START: begin
                    n_len  = '0;
                    n_pos  = '0;
                    n_play = 1'b0;
                    n_rec  = 1'b1;
                end
                arpl_pkg::OP_REC_STOP: begin
                    n_rec = 1'b0;
                end
                arpl_pkg::OP_PLAY_START: begin
                    n_rec    = 1'b0;
                    n_play   = 1'b1;
                    n_rev    = r_rev | i_in.play_reverse;
                    n_loop   = r_loop | i_in.play_loop;
                    n_bounce = r_bounce | i_in.play_bounce;
                end
                arpl_pkg::OP_PLAY_STOP: begin
                    n_play   = 1'b0;
                    n_rev    = 1'b0;
                    n_loop   = 1'b0;
                    n_bounce = 1'b0;
                    n_pos    = '0;
                end
                arpl_pkg::OP_TICK: begin
                    w_tick = 1'b1;
                    if (r_rec) begin
                        // Store the sample until the limit is reached.
                        if (r_len >= w_limit) begin
                            n_rec = 1'b0;
                        end else begin
                            o_ram_we = 1'b1;
                            n_len    = r_len + 1'b1;
                        end
                    end else if (r_play) begin
                        if (r_pos >= r_len && !r_loop) begin
                            n_play   = 1'b0;
                            n_rev    = 1'b0;
                            n_loop   = 1'b0;
                            n_bounce = 1'b0;
                            n_pos    = '0;
                        end else begin
                            // Advance the position, wrapping to the start and flipping direction in bounce mode.
                            n_rev = w_rev_eff;
                            n_pos = w_pos_base;
                            if (r_len != '0) begin
                                o_ram_re = 1'b1;
                                n_pos    = w_pos_base + 1'b1;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len    <= '0;
            r_pos    <= '0;
            r_rec    <= 1'b0;
            r_play   <= 1'b0;
            r_rev    <= 1'b0;
            r_loop   <= 1'b0;
            r_bounce <= 1'b0;
        end else begin
            r_len    <= n_len;
            r_pos    <= n_pos;
            r_rec    <= n_rec;
            r_play   <= n_play;
            r_rev    <= n_rev;
            r_loop   <= n_loop;
            r_bounce <= n_bounce;
        end
    end

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_samples <= arpl_pkg::MAX_SAMPLES_RST;
            r_out_ch      <= arpl_pkg::OUT_CH_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == arpl_pkg::CFG_MAX_SAMPLES) begin
                r_max_samples <= i_cfg_data[arpl_pkg::MAX_SAMPLES_W-1:0];
            end else if (i_cfg_idx == arpl_pkg::CFG_OUT_CHANNELS) begin
                r_out_ch <= i_cfg_data[arpl_pkg::OUT_CH_W-1:0];
            end
        end
    end

    // Tick descriptor slot.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_fire && w_tick) begin
            r_s1_valid <= 1'b1;
        end else if (i_take) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_tick) begin
            r_s1_rd      <= o_ram_re;
            r_s1_rec     <= n_rec;
            r_s1_play    <= n_play;
            r_s1_last_ch <= w_last_ch;
        end
    end

    assign o_s1.valid   = r_s1_valid;
    assign o_s1.rd      = r_s1_rd;
    assign o_s1.rec     = r_s1_rec;
    assign o_s1.play    = r_s1_play;
    assign o_s1_last_ch = r_s1_last_ch;

endmodule

### rtl/arpl_emit.sv
// ============================================================================
// Looper channel emitter
// Takes one tick descriptor and the read sample, and sends one result
// request per output channel.
// ============================================================================
module arpl_emit #(
    parameter int MAX_CHANNELS = arpl_pkg::MAX_CHANNELS_DEF,
    localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  arpl_pkg::t_s1_info            i_s1,
    input  logic [CH_W-1:0]               i_s1_last_ch,
    input  logic [arpl_pkg::SAMPLE_W-1:0] i_ram_q,
    output logic                          o_take,
    arpl_out_if.source                    o_out
);

    logic                          r_busy;
    logic [CH_W-1:0]               r_ch;
    logic [CH_W-1:0]               r_last_ch;
    logic [arpl_pkg::SAMPLE_W-1:0] r_sample;
    logic                          r_rec;
    logic                          r_play;
    logic                          w_done;

    // A new tick may load when idle or when the last channel leaves now.
    assign w_done = o_out.ready && (r_ch == r_last_ch);
    assign o_take = !r_busy || w_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (o_take) begin
            r_busy <= i_s1.valid;
        end
    end

    // Channel counter and held result.
    always_ff @(posedge i_clk) begin
        if (o_take && i_s1.valid) begin
            r_ch      <= '0;
            r_last_ch <= i_s1_last_ch;
            r_sample  <= i_s1.rd ? i_ram_q : '0;
            r_rec     <= i_s1.rec;
            r_play    <= i_s1.play;
        end else if (r_busy && o_out.ready) begin
            r_ch <= r_ch + 1'b1;
        end
    end

    assign o_out.valid        = r_busy;
    assign o_out.sample_out   = r_sample;
    assign o_out.channel      = arpl_pkg::CHANNEL_W'(r_ch);
    assign o_out.last         = (r_ch == r_last_ch);
    assign o_out.is_recording = r_rec;
    assign o_out.is_playing   = r_play;

endmodule

### rtl/arpl_chk.sv
// ============================================================================
// Looper port checker
// Watches the result channel of the looper and checks its sequencing.
// ============================================================================
`include "audio_record_playback_looper_assert.svh"

module arpl_chk (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_out_valid,
    input logic                                 i_out_ready,
    input logic signed [arpl_pkg::SAMPLE_W-1:0] i_sample_out,
    input logic [arpl_pkg::CHANNEL_W-1:0]       i_channel,
    input logic                                 i_last,
    input logic                                 i_is_recording,
    input logic                                 i_is_playing
);

    // No result request is pending right after reset.
    `ARPL_ASSERT_RST(a_quiet_after_reset, !i_rst_n |=> !i_out_valid, "result valid after reset")

    // Within a tick the channel index steps by one.
    `ARPL_ASSERT(a_channel_step, i_out_valid && i_out_ready && !i_last |=> i_out_valid && (i_channel == arpl_pkg::CHANNEL_W'($past(i_channel) + 1'b1)), "channel did not advance")

    // A burst of results starts at channel zero.
    `ARPL_ASSERT(a_first_channel, $rose(i_out_valid) |-> (i_channel == '0), "burst does not start at channel zero")

    // Recording and playback are never reported together.
    `ARPL_ASSERT(a_status_exclusive, i_out_valid |-> !(i_is_recording && i_is_playing), "recording and playing both set")

    // Nothing is played while recording.
    `ARPL_ASSERT(a_silent_recording, i_out_valid && i_is_recording |-> (i_sample_out == '0), "nonzero sample while recording")

endmodule

bind audio_record_playback_looper arpl_chk u_arpl_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_sample_out   (o_out.sample_out),
    .i_channel      (o_out.channel),
    .i_last         (o_out.last),
    .i_is_recording (o_out.is_recording),
    .i_is_playing   (o_out.is_playing)
);

### test/audio_record_playback_looper_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// Looper testbench
// Drives command and tick requests into the looper under changing register
// settings and idle patterns. A behavioral copy of the looper tracks every
// accepted request and checks each channel sample the block returns.
// ============================================================================
module audio_record_playback_looper_tb;

    import arpl_pkg::*;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 10;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_COUNT   = 8;
    localparam int PHASE_BUDGET  = 40;

    // Operation codes that the block ignores.
    localparam logic [OP_W-1:0] OP_UNKNOWN_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_UNKNOWN_LAST  = 3'd7;

    // One input request as the driver presents it.
    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [SAMPLE_W-1:0] sample;
        logic                reverse;
        logic                looped;
        logic                bounce;
    } t_request;

    // One per-channel sample as the block should return it.
    typedef struct packed {
        logic [SAMPLE_W-1:0]  sample_out;
        logic [CHANNEL_W-1:0] channel;
        logic                 last;
        logic                 is_recording;
        logic                 is_playing;
    } t_channel_sample;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    arpl_in_if  req_if ();
    arpl_out_if rsp_if ();

    audio_record_playback_looper u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (req_if),
        .o_out      (rsp_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    t_request        request_q [$];
    t_channel_sample due_samples_q [$];
    t_request        staged;
    int              requests_open = 0;
    int              counted_requests = 0;
    int              fail_count = 0;
    int              cycle_count = 0;
    int              send_idle_pct = 0;
    int              stall_pct = 0;

    // Looper state and register copies.
    logic [SAMPLE_W-1:0]      take_mem [int unsigned];
    int unsigned              take_len = 0;
    int unsigned              play_pos = 0;
    logic                     recording = 1'b0;
    logic                     playing = 1'b0;
    logic                     reverse_on = 1'b0;
    logic                     loop_on = 1'b0;
    logic                     bounce_on = 1'b0;
    logic [MAX_SAMPLES_W-1:0] limit_reg = MAX_SAMPLES_RST;
    logic [OUT_CH_W-1:0]      chan_reg = OUT_CH_RST;

    // Register settings of the random phases, extremes included.
    int unsigned phase_limit [PHASE_COUNT] =
        '{480000, 0, 1, 7, 1048575, 524288, 12, 5};
    int unsigned phase_chans [PHASE_COUNT] = '{1, 15, 0, 3, 8, 5, 2, 4};
    int          idle_send [4] = '{0, 60, 0, 8};
    int          idle_stall [4] = '{0, 0, 60, 8};

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %0h, expected %0h (cycle %0d)",
                 what, got, want, cycle_count);
        fail_count++;
    endtask

    function automatic void end_playback();
        playing    = 1'b0;
        reverse_on = 1'b0;
        loop_on    = 1'b0;
        bounce_on  = 1'b0;
        play_pos   = 0;
    endfunction

    // Sample played on one tick; records or advances the play position.
    function automatic logic [SAMPLE_W-1:0] play_tick(input logic [SAMPLE_W-1:0] smp);
        int unsigned limit;
        int unsigned addr;
        limit = (limit_reg > STORE_DEPTH_DEF) ? STORE_DEPTH_DEF : limit_reg;
        if (recording) begin
            if (take_len >= limit) begin
                recording = 1'b0;
            end else begin
                take_mem[take_len] = smp;
                take_len++;
            end
            return '0;
        end
        if (!playing) return '0;
        if (play_pos >= take_len) begin
            if (!loop_on) begin
                end_playback();
                return '0;
            end
            if (bounce_on) reverse_on = ~reverse_on;
            play_pos = 0;
            if (take_len == 0) return '0;
        end
        addr = reverse_on ? take_len - 1 - play_pos : play_pos;
        play_pos++;
        return take_mem[addr];
    endfunction

    // Applies one accepted request and queues the channel samples it causes.
    function automatic void step_looper(input t_request req);
        logic [SAMPLE_W-1:0] played;
        int unsigned         n;
        t_channel_sample     cs;
        case (req.op)
            OP_REC_START: begin
                take_len  = 0;
                play_pos  = 0;
                playing   = 1'b0;
                recording = 1'b1;
            end
            OP_REC_STOP: begin
                recording = 1'b0;
            end
            OP_PLAY_START: begin
                recording  = 1'b0;
                playing    = 1'b1;
                reverse_on = reverse_on | req.reverse;
                loop_on    = loop_on | req.looped;
                bounce_on  = bounce_on | req.bounce;
            end
            OP_PLAY_STOP: begin
                end_playback();
            end
            OP_TICK: begin
                played = play_tick(req.sample);
                n = (chan_reg == 0) ? 1 : chan_reg;
                if (n > MAX_CHANNELS_DEF) n = MAX_CHANNELS_DEF;
                for (int unsigned k = 0; k < n; k++) begin
                    cs.sample_out   = played;
                    cs.channel      = k[CHANNEL_W-1:0];
                    cs.last         = (k + 1 == n);
                    cs.is_recording = recording;
                    cs.is_playing   = playing;
                    due_samples_q.push_back(cs);
                end
            end
            default: begin
            end
        endcase
    endfunction

    task automatic add_request(input logic [OP_W-1:0] op, input logic [SAMPLE_W-1:0] smp,
                               input logic rev, input logic lp, input logic bn);
        t_request req;
        req = '{op: op, sample: smp, reverse: rev, looped: lp, bounce: bn};
        request_q.push_back(req);
        requests_open++;
        if (op <= OP_PLAY_STOP) counted_requests++;
    endtask

    task automatic add_random(input logic [OP_W-1:0] op);
        add_request(op, SAMPLE_W'($urandom()), 1'($urandom()), 1'($urandom()),
                    1'($urandom()));
    endtask

    // Mostly record-then-play sessions with random content, some noise.
    task automatic queue_random_traffic(input int budget);
        int target;
        int n;
        target = counted_requests + budget;
        while (counted_requests < target) begin
            if ($urandom_range(99) < 75) begin
                add_random(OP_REC_START);
                n = $urandom_range(0, 10);
                repeat (n) add_random(OP_TICK);
                if ($urandom_range(1)) add_random(OP_REC_STOP);
                add_random(OP_PLAY_START);
                n = $urandom_range(0, 24);
                repeat (n) add_random(OP_TICK);
                if ($urandom_range(1)) add_random(OP_PLAY_STOP);
            end else begin
                n = $urandom_range(1, 6);
                repeat (n) add_random(OP_W'($urandom_range(0, 7)));
            end
        end
    endtask

    task automatic write_register(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        if (idx == CFG_MAX_SAMPLES) limit_reg = data[MAX_SAMPLES_W-1:0];
        else chan_reg = data[OUT_CH_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Waits until every request is taken and every sample has come back.
    task automatic wait_idle();
        while (requests_open != 0 || due_samples_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_idling(input int mode);
        send_idle_pct = idle_send[mode % 4];
        stall_pct     = idle_stall[mode % 4];
    endtask

    // Request driver: holds a request until taken, then offers the next.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                step_looper(staged);
                requests_open--;
            end
            if (!req_if.valid || req_if.ready) begin
                if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    staged = request_q.pop_front();
                    req_if.valid        <= 1'b1;
                    req_if.op           <= staged.op;
                    req_if.sample_in    <= staged.sample;
                    req_if.play_reverse <= staged.reverse;
                    req_if.play_loop    <= staged.looped;
                    req_if.play_bounce  <= staged.bounce;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compares each taken sample with the oldest one due.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (due_samples_q.size() == 0) begin
                    report_mismatch("sample with none due, channel", rsp_if.channel, '0);
                end else begin
                    if (rsp_if.sample_out !== due_samples_q[0].sample_out)
                        report_mismatch("sample_out", rsp_if.sample_out,
                                        due_samples_q[0].sample_out);
                    if (rsp_if.channel !== due_samples_q[0].channel)
                        report_mismatch("channel", rsp_if.channel, due_samples_q[0].channel);
                    if (rsp_if.last !== due_samples_q[0].last)
                        report_mismatch("last", rsp_if.last, due_samples_q[0].last);
                    if (rsp_if.is_recording !== due_samples_q[0].is_recording)
                        report_mismatch("is_recording", rsp_if.is_recording,
                                        due_samples_q[0].is_recording);
                    if (rsp_if.is_playing !== due_samples_q[0].is_playing)
                        report_mismatch("is_playing", rsp_if.is_playing,
                                        due_samples_q[0].is_playing);
                    void'(due_samples_q.pop_front());
                end
            end
            rsp_if.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Run watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_idx           = CFG_MAX_SAMPLES;
        i_cfg_data          = '0;
        req_if.valid        = 1'b0;
        req_if.op           = OP_TICK;
        req_if.sample_in    = '0;
        req_if.play_reverse = 1'b0;
        req_if.play_loop    = 1'b0;
        req_if.play_bounce  = 1'b0;
        rsp_if.ready        = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        // Directed part: a limit of three samples and all eight channels.
        write_register(CFG_MAX_SAMPLES, 20'd3);
        write_register(CFG_OUT_CHANNELS, 20'd8);
        set_idling(0);
        // Idle block: a tick gives zeros, unknown codes give nothing.
        add_request(OP_TICK, 16'h1234, 1'b1, 1'b1, 1'b1);
        add_request(OP_UNKNOWN_FIRST, 16'hFFFF, 1'b1, 1'b1, 1'b1);
        add_request(OP_UNKNOWN_LAST, 16'h0000, 1'b0, 1'b0, 1'b0);
        // Playback of an empty take without looping ends on the first tick.
        add_request(OP_PLAY_START, 16'h0000, 1'b0, 1'b0, 1'b0);
        add_request(OP_TICK, 16'h0000, 1'b0, 1'b0, 1'b0);
        // Record up to the limit; the tick after it ends the take.
        add_request(OP_REC_START, 16'h0000, 1'b0, 1'b0, 1'b0);
        add_request(OP_TICK, 16'h7FFF, 1'b0, 1'b0, 1'b0);
        add_request(OP_TICK, 16'h8000, 1'b0, 1'b0, 1'b0);
        add_request(OP_TICK, 16'h0001, 1'b0, 1'b0, 1'b0);
        add_request(OP_TICK, 16'hFFFF, 1'b0, 1'b0, 1'b0);
        // Forward pass; reaching the end stops playback.
        add_request(OP_PLAY_START, 16'h0000, 1'b0, 1'b0, 1'b0);
        repeat (4) add_request(OP_TICK, 16'h5555, 1'b0, 1'b0, 1'b0);
        // Reversed, looped and back and forth: direction flips at each wrap.
        add_request(OP_PLAY_START, 16'h0000, 1'b1, 1'b1, 1'b1);
        repeat (5) add_request(OP_TICK, 16'hAAAA, 1'b0, 1'b0, 1'b0);
        add_request(OP_PLAY_STOP, 16'h0000, 1'b1, 1'b1, 1'b1);
        // Empty take while looping: zeros while the direction keeps toggling.
        add_request(OP_REC_START, 16'h0000, 1'b0, 1'b0, 1'b0);
        add_request(OP_REC_STOP, 16'h0000, 1'b0, 1'b0, 1'b0);
        add_request(OP_PLAY_START, 16'h0000, 1'b0, 1'b1, 1'b1);
        add_request(OP_TICK, 16'h0000, 1'b0, 1'b0, 1'b0);
        add_request(OP_TICK, 16'h0000, 1'b0, 1'b0, 1'b0);
        add_request(OP_PLAY_STOP, 16'h0000, 1'b0, 1'b0, 1'b0);
        wait_idle();

        // Random phases, each under its own settings and idle pattern.
        for (int p = 0; p < PHASE_COUNT; p++) begin
            write_register(CFG_MAX_SAMPLES, CFG_DATA_W'(phase_limit[p]));
            write_register(CFG_OUT_CHANNELS,
                           {16'($urandom()), OUT_CH_W'(phase_chans[p])});
            set_idling(p);
            queue_random_traffic(PHASE_BUDGET);
            wait_idle();
        end

        if (due_samples_q.size() != 0)
            report_mismatch("samples never returned", due_samples_q.size(), '0);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
